[design/hps_pkg.sv]
package hps_pkg;

    localparam int MAX_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 24;

    // fixed field widths of the stream payload
    localparam int BIN_W    = 24;
    localparam int PWIDTH_W = 9;
    localparam int HEIGHT_W = 24;
    localparam int TOP_W    = 8;
    localparam int SUM_W    = 40;
    localparam int EDGE_W   = 9;

    localparam int S_TDATA_W = 24;
    localparam int M_FIELD_W = PWIDTH_W + HEIGHT_W + TOP_W + SUM_W + 2 * EDGE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic                peak_valid;
        logic                end_of_list;
        logic [PWIDTH_W-1:0] peak_width;
        logic [HEIGHT_W-1:0] peak_height;
        logic [TOP_W-1:0]    top_position;
        logic [SUM_W-1:0]    weighted_sum;
        logic [EDGE_W-1:0]   left_edge;
        logic [EDGE_W-1:0]   right_edge;
    } result_t;

endpackage

[design/hps_product.sv]
module hps_product #(
    parameter int MAX_BINS   = hps_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = hps_pkg::COUNT_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          take,
    input  logic [$clog2(MAX_BINS)-1:0]                   idx_next,
    input  logic [COUNT_BITS-1:0]                         cur,
    output logic [$clog2(MAX_BINS)+COUNT_BITS-1:0]        prod
);
    import hps_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BINS);
    localparam int PROD_W = IDX_W + COUNT_BITS;

    logic [PROD_W-1:0] prod_reg;

    // index times value of the bin just taken, ready for the next transfer
    always_ff @(posedge aclk) begin
        if (take) begin
            prod_reg <= PROD_W'(idx_next) * PROD_W'(cur);
        end
    end

    assign prod = prod_reg;

endmodule

[design/hps_tracker.sv]
module hps_tracker #(
    parameter int MAX_BINS   = hps_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = hps_pkg::COUNT_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   take,
    input  logic [COUNT_BITS-1:0]                  cur,
    input  logic                                   last,
    input  logic [$clog2(MAX_BINS)+COUNT_BITS-1:0] prod,
    output logic [$clog2(MAX_BINS)-1:0]            idx_next,
    output hps_pkg::result_t                       res,
    output logic                                   res_valid
);
    import hps_pkg::*;

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int WID_W = $clog2(MAX_BINS + 1);

    logic [COUNT_BITS-1:0] prev_reg,     prev_next;
    logic [IDX_W-1:0]      idx_reg;
    logic                  have_prev_reg, have_prev_next;
    logic                  open_reg,     open_next;
    logic                  rising_reg,   rising_next;
    logic                  emitted_reg,  emitted_next;
    logic [WID_W-1:0]      width_reg,    width_next;
    logic [COUNT_BITS-1:0] height_reg,   height_next;
    logic [IDX_W-1:0]      top_reg,      top_next;
    logic [SUM_W-1:0]      sum_reg,      sum_next;
    logic [WID_W-1:0]      left_reg,     left_next;

    logic [SUM_W-1:0]      prod_sum;
    logic [SUM_W-1:0]      sum_acc;
    logic [WID_W-1:0]      width_inc;
    logic [WID_W-1:0]      i_plus1;
    logic                  close_now;
    logic                  flush;
    logic                  pk_valid;
    logic [WID_W-1:0]      pk_width;
    logic [COUNT_BITS-1:0] pk_height;
    logic [IDX_W-1:0]      pk_top;
    logic [SUM_W-1:0]      pk_sum;
    logic [WID_W-1:0]      pk_left;
    logic [WID_W-1:0]      pk_right;

    assign prod_sum  = SUM_W'(prod);
    assign sum_acc   = sum_reg + prod_sum;
    assign width_inc = (width_reg < WID_W'(MAX_BINS)) ? width_reg + 1'b1 : width_reg;
    assign i_plus1   = WID_W'(idx_reg) + 1'b1;

    always_comb begin
        prev_next      = cur;
        have_prev_next = 1'b1;
        idx_next       = idx_reg;
        open_next      = open_reg;
        rising_next    = rising_reg;
        emitted_next   = emitted_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        top_next       = top_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        close_now      = 1'b0;

        if (have_prev_reg) begin
            if (open_reg) begin
                width_next = width_inc;
                sum_next   = sum_acc;
                if (rising_reg) begin
                    if (cur < prev_reg) begin
                        height_next = prev_reg;
                        top_next    = idx_reg;
                        rising_next = 1'b0;
                    end
                end else if (cur > prev_reg) begin
                    // rise after the fall: close and reopen at the next bin
                    close_now    = 1'b1;
                    emitted_next = 1'b0;
                    width_next   = '0;
                    height_next  = '0;
                    top_next     = '0;
                    sum_next     = '0;
                    left_next    = i_plus1;
                    rising_next  = 1'b1;
                end else if (cur == prev_reg) begin
                    close_now    = 1'b1;
                    emitted_next = 1'b1;
                    rising_next  = 1'b0;
                    open_next    = 1'b0;
                end
            end else if (cur > prev_reg) begin
                width_next   = WID_W'(1);
                height_next  = prev_reg;
                top_next     = idx_reg;
                sum_next     = prod_sum;
                left_next    = WID_W'(idx_reg);
                emitted_next = 1'b0;
                rising_next  = 1'b1;
                open_next    = 1'b1;
            end
            if (idx_reg != IDX_W'(MAX_BINS - 1)) begin
                idx_next = idx_reg + 1'b1;
            end
        end else begin
            idx_next = '0;
        end

        flush = last && !close_now && !emitted_next && (width_next != '0);

        // a closing peak shows its totals before the clear
        if (close_now) begin
            pk_width  = width_inc;
            pk_height = height_reg;
            pk_top    = top_reg;
            pk_sum    = sum_acc;
            pk_left   = left_reg;
            pk_right  = i_plus1;
        end else begin
            pk_width  = width_next;
            pk_height = height_next;
            pk_top    = top_next;
            pk_sum    = sum_next;
            pk_left   = left_next;
            pk_right  = WID_W'(idx_next) + 1'b1;
        end
        pk_valid = close_now || flush;

        res.peak_valid  = pk_valid;
        res.end_of_list = last;
        if (pk_valid) begin
            res.peak_width   = PWIDTH_W'(pk_width);
            res.peak_height  = HEIGHT_W'(pk_height);
            res.top_position = TOP_W'(pk_top);
            res.weighted_sum = pk_sum;
            res.left_edge    = EDGE_W'(pk_left);
            res.right_edge   = EDGE_W'(pk_right);
        end else begin
            res.peak_width   = '0;
            res.peak_height  = '0;
            res.top_position = '0;
            res.weighted_sum = '0;
            res.left_edge    = '0;
            res.right_edge   = '0;
        end
        res_valid = pk_valid || last;

        // end of histogram: back to the reset state
        if (last) begin
            have_prev_next = 1'b0;
            open_next      = 1'b0;
            rising_next    = 1'b0;
            emitted_next   = 1'b0;
            width_next     = '0;
            height_next    = '0;
            top_next       = '0;
            sum_next       = '0;
            left_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            open_reg      <= 1'b0;
            rising_reg    <= 1'b0;
            emitted_reg   <= 1'b0;
            width_reg     <= '0;
            idx_reg       <= '0;
        end else if (take) begin
            have_prev_reg <= have_prev_next;
            open_reg      <= open_next;
            rising_reg    <= rising_next;
            emitted_reg   <= emitted_next;
            width_reg     <= width_next;
            idx_reg       <= last ? '0 : idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            prev_reg   <= prev_next;
            height_reg <= height_next;
            top_reg    <= top_next;
            sum_reg    <= sum_next;
            left_reg   <= left_next;
        end
    end

endmodule

[design/hps_out_stage.sv]
module hps_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  hps_pkg::result_t res,
    input  logic             res_valid,
    input  logic             m_tready,
    output logic             m_tvalid,
    output hps_pkg::result_t m_res,
    output logic             in_ready
);
    import hps_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take && res_valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

[design/histogram_peak_segmenter.sv]
// Splits a histogram, streamed one bin per transfer in index order with tlast
// on the final bin, into peaks. A peak opens where the bins rise, takes its
// top at the first fall, and closes on a rise or a flat step after the fall;
// an open peak is flushed on the last bin, and the last bin itself is never
// counted into a peak. A result transfer carries one finished peak (tuser
// high); the transfer caused by the last bin always comes and has tlast set,
// with all data zero if it carries no peak. The block takes one bin every
// cycle unless the output stalls, and registers its result on the transfer,
// a rate set by the compare and 40-bit accumulate on the tracker state, with
// the index-times-count product formed one bin ahead in its own register.
// The stream may start again with a new histogram right after tlast.
module histogram_peak_segmenter #(
    parameter int MAX_BINS   = hps_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = hps_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hps_pkg::S_TDATA_W-1:0] s_tdata,   // [23:0] bin_count
    input  logic                          s_tlast,   // last_bin
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [8:0] peak_width, [32:9] peak_height, [40:33] top_position,
    // [80:41] weighted_sum, [89:81] left_edge, [98:90] right_edge, zero above
    output logic [hps_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,   // peak_valid
    output logic                          m_tlast    // end_of_list
);
    import hps_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BINS);
    localparam int PROD_W = IDX_W + COUNT_BITS;

    logic                  take;
    logic [COUNT_BITS-1:0] cur;
    logic [IDX_W-1:0]      idx_next;
    logic [PROD_W-1:0]     prod;
    result_t               res;
    logic                  res_valid;
    result_t               m_res;

    assign take = s_tvalid && s_tready;
    assign cur  = COUNT_BITS'(s_tdata[BIN_W-1:0]);

    hps_product #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_product (
        .aclk     (aclk),
        .take     (take),
        .idx_next (idx_next),
        .cur      (cur),
        .prod     (prod)
    );

    hps_tracker #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .cur       (cur),
        .last      (s_tlast),
        .prod      (prod),
        .idx_next  (idx_next),
        .res       (res),
        .res_valid (res_valid)
    );

    hps_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .res       (res),
        .res_valid (res_valid),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_res     (m_res),
        .in_ready  (s_tready)
    );

    assign m_tdata = M_TDATA_W'({m_res.right_edge, m_res.left_edge, m_res.weighted_sum,
                                 m_res.top_position, m_res.peak_height, m_res.peak_width});
    assign m_tuser = m_res.peak_valid;
    assign m_tlast = m_res.end_of_list;

    // an empty output register never holds off the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // the last bin always yields a tlast transfer on the next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && m_tlast))
        else $error("last bin produced no end-of-list result");

    // a result without a peak is only the end marker, with zero data
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("result without peak is not a clean end marker");

    // every finished peak has counted at least one bin
    a_peak_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[PWIDTH_W-1:0] != '0))
        else $error("peak delivered with zero width");

endmodule

[sim/histogram_peak_segmenter_test.sv]
`timescale 1ns / 1ps

module histogram_peak_segmenter_test;

    import hps_pkg::*;

    localparam int          BIN_LIMIT      = MAX_BINS_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned HOLD_AFTER     = 60;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned LONG_BINS      = 264;
    localparam int unsigned SHORT_BINS     = 160;
    localparam logic [23:0] FULL_COUNT     = 24'hFFFFFF;

    typedef struct packed {
        logic        last;
        logic [23:0] count;
    } bin_item_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    histogram_peak_segmenter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bin_item_t   bin_q[$];
    result_t     peak_q[$];
    int unsigned mismatches    = 0;
    int unsigned histograms    = 0;
    int unsigned bins_sent     = 0;
    int unsigned results_seen  = 0;
    int unsigned peaks_seen    = 0;
    int unsigned cycle_no      = 0;
    int unsigned idle_cycles   = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned recv_gap      = 0;

    // peak tracker state
    logic [23:0] prev_count   = '0;
    int unsigned bin_idx      = 0;
    bit          have_prev    = 1'b0;
    bit          peak_open    = 1'b0;
    bit          rising       = 1'b0;
    bit          peak_flushed = 1'b0;
    int unsigned acc_width    = 0;
    logic [23:0] acc_height   = '0;
    logic [7:0]  acc_top      = '0;
    logic [39:0] acc_sum      = '0;
    int unsigned acc_left     = 0;

    // no idling at all while cycle_no % 1000 is below 200
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((cycle_no % 1000) < 200 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic result_t finished_peak(int unsigned right);
        result_t r;
        r              = '0;
        r.peak_valid   = 1'b1;
        r.peak_width   = acc_width[PWIDTH_W-1:0];
        r.peak_height  = acc_height;
        r.top_position = acc_top;
        r.weighted_sum = acc_sum;
        r.left_edge    = acc_left[EDGE_W-1:0];
        r.right_edge   = right[EDGE_W-1:0];
        return r;
    endfunction

    function automatic void clear_tracker();
        prev_count   = '0;
        bin_idx      = 0;
        have_prev    = 1'b0;
        peak_open    = 1'b0;
        rising       = 1'b0;
        peak_flushed = 1'b0;
        acc_width    = 0;
        acc_height   = '0;
        acc_top      = '0;
        acc_sum      = '0;
        acc_left     = 0;
    endfunction

    // advance the tracker by one bin and queue the peak it finishes, if any
    function automatic void track_bin(logic [23:0] cur, logic last);
        result_t     r;
        bit          done;
        int unsigned i;
        logic [23:0] v;
        r    = '0;
        done = 1'b0;
        if (have_prev) begin
            i = bin_idx;
            v = prev_count;
            if (peak_open) begin
                if (acc_width < BIN_LIMIT)
                    acc_width++;
                acc_sum = acc_sum + 40'(i) * 40'(v);
                if (rising) begin
                    if (cur < v) begin
                        acc_height = v;
                        acc_top    = i[7:0];
                        rising     = 1'b0;
                    end
                end else if (cur > v) begin
                    // rise after the fall: close and open the next peak at once
                    r            = finished_peak(i + 1);
                    done         = 1'b1;
                    peak_flushed = 1'b0;
                    acc_width    = 0;
                    acc_height   = '0;
                    acc_top      = '0;
                    acc_sum      = '0;
                    acc_left     = i + 1;
                    rising       = 1'b1;
                end else if (cur == v) begin
                    r            = finished_peak(i + 1);
                    done         = 1'b1;
                    peak_flushed = 1'b1;
                    rising       = 1'b0;
                    peak_open    = 1'b0;
                end
            end else if (cur > v) begin
                acc_width    = 1;
                acc_height   = v;
                acc_top      = i[7:0];
                acc_sum      = 40'(i) * 40'(v);
                acc_left     = i;
                peak_flushed = 1'b0;
                rising       = 1'b1;
                peak_open    = 1'b1;
            end
            if (bin_idx < BIN_LIMIT - 1)
                bin_idx++;
        end else begin
            bin_idx = 0;
        end
        prev_count = cur;
        have_prev  = 1'b1;
        if (last) begin
            if (!done && !peak_flushed && acc_width != 0)
                r = finished_peak(bin_idx + 1);
            r.end_of_list = 1'b1;
            clear_tracker();
        end
        if (done || last)
            peak_q = {peak_q, r};
    endfunction

    task automatic add_bin(logic [23:0] count, logic last);
        bin_item_t b;
        b.count = count;
        b.last  = last;
        bin_q = {bin_q, b};
        if (last)
            histograms++;
    endtask

    task automatic add_histogram(int unsigned len, int unsigned shape);
        logic [23:0] c;
        logic [23:0] base;
        int unsigned j;
        int unsigned k;
        base = 24'($urandom_range(0, 1000));
        c    = base;
        for (j = 0; j < len; j++) begin
            k = j % 5;
            case (shape)
                0: c = 24'($urandom_range(0, 3));
                1: c = c + 24'($urandom_range(0, 4)) - 24'd2;
                2: c = 24'($urandom);
                default: c = base + 24'((k < 3) ? k : 5 - k);
            endcase
            add_bin(c, j == len - 1);
        end
    endtask

    task automatic check_field(string name, logic [39:0] want, logic [39:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // sender: one transfer per handshake, random gaps between items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_bin(s_tdata[BIN_W-1:0], s_tlast);
                bins_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (bin_q.size() != 0) begin
                    s_tdata  <= bin_q[0].count;
                    s_tlast  <= bin_q[0].last;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                    void'(bin_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check every result transfer against the oldest expected peak
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser)
                    peaks_seen++;
                if (peak_q.size() == 0) begin
                    $error("result transfer with no peak expected");
                    mismatches++;
                end else begin
                    want = peak_q.pop_front();
                    check_field("peak_valid", 40'(want.peak_valid), 40'(m_tuser));
                    check_field("end_of_list", 40'(want.end_of_list), 40'(m_tlast));
                    check_field("peak_width", 40'(want.peak_width), 40'(m_tdata[8:0]));
                    check_field("peak_height", 40'(want.peak_height), 40'(m_tdata[32:9]));
                    check_field("top_position", 40'(want.top_position),
                                40'(m_tdata[40:33]));
                    check_field("weighted_sum", want.weighted_sum, m_tdata[80:41]);
                    check_field("left_edge", 40'(want.left_edge), 40'(m_tdata[89:81]));
                    check_field("right_edge", 40'(want.right_edge), 40'(m_tdata[98:90]));
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // one long hold-off on the result side early in the random traffic, and the watchdog
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bins_sent >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("histogram_peak_segmenter_test: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned short_bins;
        int unsigned len;
        int unsigned r;
        int unsigned j;
        bit          long_added;

        // a single-bin histogram
        add_bin(24'd7, 1'b1);
        // rise, fall, then a flat step on the last bin
        add_bin(24'd0, 1'b0); add_bin(FULL_COUNT, 1'b0); add_bin(24'd0, 1'b0);
        add_bin(24'd0, 1'b1);
        // rise after a fall closes one peak and opens the next
        add_bin(24'd1, 1'b0); add_bin(24'd5, 1'b0); add_bin(24'd3, 1'b0);
        add_bin(24'd9, 1'b0); add_bin(24'd2, 1'b0); add_bin(24'd2, 1'b1);
        // flat histogram: end marker only
        add_bin(24'd4, 1'b0); add_bin(24'd4, 1'b0); add_bin(24'd4, 1'b1);
        // rising to the end: flushed without a top; then a fall on the last bin
        add_bin(24'd10, 1'b0); add_bin(24'd20, 1'b0); add_bin(24'd30, 1'b1);
        add_bin(FULL_COUNT, 1'b0); add_bin(24'd0, 1'b0); add_bin(FULL_COUNT, 1'b0);
        add_bin(24'h800000, 1'b1);
        // falling only
        add_bin(24'd3, 1'b0); add_bin(24'd2, 1'b0); add_bin(24'd1, 1'b0);
        add_bin(24'd0, 1'b1);

        short_bins = 0;
        long_added = 1'b0;
        while (short_bins < SHORT_BINS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                              : $urandom_range(1, 16);
            r   = $urandom_range(0, 9);
            add_histogram(len, (r < 2) ? 0 : (r < 5) ? 1 : (r < 7) ? 2 : 3);
            short_bins += len;
            if (!long_added && short_bins > SHORT_BINS / 2) begin
                // one rise then a long plateau at full count: saturates the index
                // and the width
                add_bin(24'd0, 1'b0);
                for (j = 1; j < LONG_BINS; j++)
                    add_bin(FULL_COUNT, j == LONG_BINS - 1);
                long_added = 1'b1;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (bin_q.size() != 0 || s_tvalid || peak_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (peak_q.size() != 0) begin
            $error("%0d expected results never arrived", peak_q.size());
            mismatches++;
        end

        $display("run covered %0d histograms, %0d bins, %0d results (%0d peaks)",
                 histograms, bins_sent, results_seen, peaks_seen);
        $display("including saturated index and width, and a long output stall");
        if (mismatches == 0)
            $display("histogram_peak_segmenter_test: PASS");
        else
            $display("histogram_peak_segmenter_test: FAIL");
        $finish;
    end

endmodule
